FILE: hw/rtl/ofs_pkg.sv
// Package for the overwriting byte FIFO with search.
// Holds sizes, field widths, operation and status codes, and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package ofs_pkg;

	localparam int DEPTH   = 64;
	localparam int PTR_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);

	localparam int KIND_W  = 2;
	localparam int BYTE_W  = 8;
	localparam int RCNT_W  = 7;
	localparam int STAT_W  = 2;
	localparam int POS_W   = 6;
	localparam int USED_W  = 7;

	typedef logic [PTR_W-1:0]  ptr_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [BYTE_W-1:0] byte_t;

	typedef enum logic [KIND_W-1:0] {
		K_WRITE = 2'd0,
		K_READ  = 2'd1,
		K_FIND  = 2'd2,
		K_CLEAR = 2'd3
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 2'd0,
		ST_SHORT    = 2'd1,
		ST_NOTFOUND = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_FIND
	} state_t;

	// Advance a slot pointer with wrap at DEPTH.
	function automatic ptr_t next_slot(input ptr_t p);
		next_slot = (p == PTR_W'(DEPTH - 1)) ? '0 : ptr_t'(p + 1'b1);
	endfunction

endpackage

FILE: hw/rtl/ofs_if.sv
// Channel interfaces for the overwriting byte FIFO: request and result beats.
// Depends on ofs_pkg for field widths.
`timescale 1ns / 1ps

interface ofs_req_if import ofs_pkg::*;;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [BYTE_W-1:0] data_byte;
	logic [RCNT_W-1:0] read_count;

	modport source (output valid, kind, data_byte, read_count, input ready);
	modport sink   (input valid, kind, data_byte, read_count, output ready);
endinterface

interface ofs_rsp_if import ofs_pkg::*;;
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [BYTE_W-1:0] read_byte;
	logic [POS_W-1:0]  position;
	logic              last;
	logic [USED_W-1:0] used_count;
	logic              overwrote;

	modport source (output valid, status, read_byte, position, last, used_count, overwrote,
		input ready);
	modport sink   (input valid, status, read_byte, position, last, used_count, overwrote,
		output ready);
endinterface

FILE: hw/rtl/ofs_store.sv
// Byte storage for the FIFO: one write port, one read port with enable.
// Read data is registered and holds while no read is issued.
// Depends on ofs_pkg.
`timescale 1ns / 1ps

module ofs_store import ofs_pkg::*; (
	input  logic  clk,
	input  logic  we,
	input  ptr_t  waddr,
	input  byte_t wdata,
	input  logic  re,
	input  ptr_t  raddr,
	output byte_t rdata
);

	byte_t mem [DEPTH];
	byte_t rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, hold data between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/overwriting_byte_fifo_with_search.sv
// Top level of the overwriting byte FIFO with search.
// Depends on ofs_pkg, ofs_if (ofs_req_if, ofs_rsp_if) and ofs_store.
//
//   channel  dir  beat carries
//   req      in   kind, data_byte, read_count
//   rsp      out  status, read_byte, position, last, used_count, overwrote
//
// Write, clear, a short or zero-length read and a find on an empty FIFO load
// their result beat in the accepting cycle. An accepted read of N bytes comes
// out of the registered store read one byte per cycle while rsp is not
// stalled; a find walks at most the held bytes the same way, paced by the
// single read port of the store. Requests are taken only between walks.
// arst_n clears pointers, count and the sequencer; stored bytes are not cleared.
// A stalled rsp holds the output register and pauses the walk in place.
`timescale 1ns / 1ps

module overwriting_byte_fifo_with_search import ofs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	ofs_req_if.sink   req,
	ofs_rsp_if.source rsp
);

	state_t state_q, state_d;
	ptr_t   wp_q, rp_q, iss_ptr_q;
	cnt_t   held_q, iss_left_q, rem_q;
	logic   s1_valid_q;
	ptr_t   slot_s1;
	byte_t  target_q;
	byte_t  rd_data;

	logic   out_free, accept, issue, consume, match, walk_done;
	logic   req_short, start_read, start_find;
	kind_t  req_kind;

	logic              emit;
	status_t           e_status;
	byte_t             e_byte;
	logic [POS_W-1:0]  e_pos;
	logic              e_last;
	logic [USED_W-1:0] e_used;
	logic              e_ovw;

	logic              rsp_valid_q;
	status_t           rsp_status_q;
	byte_t             rsp_byte_q;
	logic [POS_W-1:0]  rsp_pos_q;
	logic              rsp_last_q;
	logic [USED_W-1:0] rsp_used_q;
	logic              rsp_ovw_q;

	// store
	ofs_store u_store (
		.clk   (clk),
		.we    (accept && (req_kind == K_WRITE)),
		.waddr (wp_q),
		.wdata (req.data_byte),
		.re    (issue),
		.raddr (iss_ptr_q),
		.rdata (rd_data)
	);

	// handshake and walk control
	assign req_kind   = kind_t'(req.kind);
	assign out_free   = !rsp_valid_q || rsp.ready;
	assign req.ready  = (state_q == S_IDLE) && out_free;
	assign accept     = req.valid && req.ready;
	assign req_short  = (held_q == '0) || (RCNT_W'(held_q) < req.read_count);
	assign start_read = accept && (req_kind == K_READ) && !req_short
		&& (req.read_count != '0);
	assign start_find = accept && (req_kind == K_FIND) && (held_q != '0);
	assign match      = (rd_data == target_q);
	assign consume    = s1_valid_q && out_free;
	assign walk_done  = consume && ((rem_q == cnt_t'(1)) || ((state_q == S_FIND) && match));
	assign issue      = (state_q != S_IDLE) && (iss_left_q != '0)
		&& (!s1_valid_q || consume) && !walk_done;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start_read) begin
					state_d = S_READ;
				end else if (start_find) begin
					state_d = S_FIND;
				end
			end
			S_READ, S_FIND: begin
				if (walk_done) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// result beat to load
	always_comb begin
		emit     = 1'b0;
		e_status = ST_OK;
		e_byte   = '0;
		e_pos    = '0;
		e_last   = 1'b1;
		e_used   = USED_W'(held_q);
		e_ovw    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (req_kind)
						K_WRITE: begin
							emit = 1'b1;
							if (held_q == CNT_W'(DEPTH)) begin
								e_ovw = 1'b1;
							end else begin
								e_used = USED_W'(cnt_t'(held_q + 1'b1));
							end
						end
						K_READ: begin
							if (req_short) begin
								emit     = 1'b1;
								e_status = ST_SHORT;
							end else if (req.read_count == '0) begin
								emit = 1'b1;
							end
						end
						K_FIND: begin
							if (held_q == '0) begin
								emit     = 1'b1;
								e_status = ST_NOTFOUND;
							end
						end
						K_CLEAR: begin
							emit   = 1'b1;
							e_used = '0;
						end
						default: emit = 1'b0;
					endcase
				end
			end
			S_READ: begin
				if (consume) begin
					emit   = 1'b1;
					e_byte = rd_data;
					e_last = (rem_q == cnt_t'(1));
					e_used = USED_W'(cnt_t'(held_q - 1'b1));
				end
			end
			S_FIND: begin
				if (consume) begin
					if (match) begin
						emit   = 1'b1;
						e_pos  = POS_W'(slot_s1);
						e_used = USED_W'(cnt_t'(held_q - 1'b1));
					end else if (rem_q == cnt_t'(1)) begin
						emit     = 1'b1;
						e_status = ST_NOTFOUND;
						e_used   = '0;
					end
				end
			end
			default: emit = 1'b0;
		endcase
	end

	// sequencer and walk counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			s1_valid_q <= 1'b0;
			iss_ptr_q  <= '0;
			iss_left_q <= '0;
			rem_q      <= '0;
		end else begin
			state_q <= state_d;
			if (issue) begin
				s1_valid_q <= 1'b1;
			end else if (consume) begin
				s1_valid_q <= 1'b0;
			end
			if (start_read) begin
				iss_ptr_q  <= rp_q;
				iss_left_q <= cnt_t'(req.read_count);
				rem_q      <= cnt_t'(req.read_count);
			end else if (start_find) begin
				iss_ptr_q  <= rp_q;
				iss_left_q <= held_q;
				rem_q      <= held_q;
			end else begin
				if (issue) begin
					iss_ptr_q  <= next_slot(iss_ptr_q);
					iss_left_q <= iss_left_q - 1'b1;
				end
				if (consume) begin
					rem_q <= rem_q - 1'b1;
				end
			end
		end
	end

	// slot of the byte in flight, search target
	always_ff @(posedge clk) begin
		if (issue) begin
			slot_s1 <= iss_ptr_q;
		end
		if (start_find) begin
			target_q <= req.data_byte;
		end
	end

	// pointers and held count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			held_q <= '0;
		end else if (accept && (req_kind == K_WRITE)) begin
			wp_q <= next_slot(wp_q);
			if (held_q == CNT_W'(DEPTH)) begin
				rp_q <= next_slot(wp_q);
			end else begin
				held_q <= held_q + 1'b1;
			end
		end else if (accept && (req_kind == K_CLEAR)) begin
			wp_q   <= '0;
			rp_q   <= '0;
			held_q <= '0;
		end else if (consume) begin
			if ((state_q == S_FIND) && !match && (rem_q == cnt_t'(1))) begin
				rp_q   <= wp_q;
				held_q <= '0;
			end else begin
				rp_q   <= next_slot(slot_s1);
				held_q <= held_q - 1'b1;
			end
		end
	end

	// output register: load a new beat or drop the taken one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_status_q <= e_status;
			rsp_byte_q   <= e_byte;
			rsp_pos_q    <= e_pos;
			rsp_last_q   <= e_last;
			rsp_used_q   <= e_used;
			rsp_ovw_q    <= e_ovw;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.read_byte  = rsp_byte_q;
	assign rsp.position   = rsp_pos_q;
	assign rsp.last       = rsp_last_q;
	assign rsp.used_count = rsp_used_q;
	assign rsp.overwrote  = rsp_ovw_q;

endmodule
